>>> src/scba_pkg.sv
package scba_pkg;

  localparam int GAIN_FRAC_BITS = 10;

  localparam int PIX_W = 8;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CONTRAST   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'b1;

  localparam logic [CFG_W-1:0] CONTRAST_RST   = 8'd20;
  localparam logic [CFG_W-1:0] BRIGHTNESS_RST = 8'd100;

  // Pipeline depth of one channel.
  localparam int STAGES = 6;

  // Steepness |t| in Q4.8, found as (d * contrast * 64 + 637) / 1275.
  localparam int NUM_W = 22;
  localparam int TA_W = 12;
  localparam int RECIP_SHIFT = 32;
  localparam int QPROD_W = NUM_W + NUM_W;
  localparam logic [NUM_W-1:0] DIV_RECIP = 22'd3368601;
  localparam logic [NUM_W-1:0] DIV_DEN   = 22'd1275;
  localparam logic [NUM_W-1:0] DIV_BIAS  = 22'd637;
  localparam logic [TA_W:0]    TA_MAX    = 13'd4095;

  // Sigmoid in unsigned Q1.16.
  localparam int SIG_W = 17;
  localparam int FRAC_W = 7;
  localparam int IDX_W = 5;
  localparam int IPROD_W = 24;
  localparam logic [SIG_W-1:0] SIG_ONE   = 17'd65536;
  localparam logic [SIG_W-1:0] GAIN_BIAS = 17'd19661;

  // Gain in unsigned Q1.GAIN_FRAC_BITS.
  localparam int GAIN_W = GAIN_FRAC_BITS + 1;
  localparam int GSH_W = SIG_W + GAIN_FRAC_BITS + 1;
  localparam int Y_W = GAIN_FRAC_BITS + 10;
  localparam int Q_W = 10;
  localparam logic [Q_W-1:0] BRIGHT_OFFS = 10'd100;
  localparam logic [Q_W-1:0] PIX_MAX     = 10'd255;

  typedef struct packed {
    logic [STAGES-1:0] load;
  } scba_ctl_t;

  function automatic logic [SIG_W-1:0] sig_val(input logic [IDX_W:0] k);
    logic [SIG_W-1:0] v;
    case (k)
      6'd0:    v = 17'd32768;
      6'd1:    v = 17'd40793;
      6'd2:    v = 17'd47911;
      6'd3:    v = 17'd53581;
      6'd4:    v = 17'd57724;
      6'd5:    v = 17'd60565;
      6'd6:    v = 17'd62428;
      6'd7:    v = 17'd63615;
      6'd8:    v = 17'd64357;
      6'd9:    v = 17'd64816;
      6'd10:   v = 17'd65097;
      6'd11:   v = 17'd65269;
      6'd12:   v = 17'd65374;
      6'd13:   v = 17'd65438;
      6'd14:   v = 17'd65476;
      6'd15:   v = 17'd65500;
      6'd16:   v = 17'd65514;
      6'd17:   v = 17'd65523;
      6'd18:   v = 17'd65528;
      6'd19:   v = 17'd65531;
      6'd20:   v = 17'd65533;
      6'd21:   v = 17'd65534;
      6'd22:   v = 17'd65535;
      6'd23:   v = 17'd65535;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

>>> src/scba_in_if.sv
interface scba_in_if;
  logic                     valid;
  logic                     ready;
  logic [scba_pkg::PIX_W-1:0] in_blue;
  logic [scba_pkg::PIX_W-1:0] in_green;
  logic [scba_pkg::PIX_W-1:0] in_red;

  modport source (output valid, output in_blue, output in_green, output in_red, input ready);
  modport sink (input valid, input in_blue, input in_green, input in_red, output ready);
endinterface

>>> src/scba_out_if.sv
interface scba_out_if;
  logic                     valid;
  logic                     ready;
  logic [scba_pkg::PIX_W-1:0] out_blue;
  logic [scba_pkg::PIX_W-1:0] out_green;
  logic [scba_pkg::PIX_W-1:0] out_red;

  modport source (output valid, output out_blue, output out_green, output out_red, input ready);
  modport sink (input valid, input out_blue, input out_green, input out_red, output ready);
endinterface

>>> src/scba_cfg_if.sv
interface scba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [scba_pkg::CFG_IDX_W-1:0]   index;
  logic [scba_pkg::CFG_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/scba_chan.sv
module scba_chan (
  input  logic                          clk,
  input  scba_pkg::scba_ctl_t           ctl,
  input  logic [scba_pkg::PIX_W-1:0]    pix_i,
  input  logic [scba_pkg::CFG_W-1:0]    contrast_i,
  input  logic [scba_pkg::CFG_W-1:0]    brightness_i,
  output logic [scba_pkg::PIX_W-1:0]    pix_o
);

  // Stage A: distance from mid-gray times contrast.
  logic [scba_pkg::PIX_W:0]       dbl;
  logic                           neg_a;
  logic [scba_pkg::PIX_W:0]       dist9;
  logic [2*scba_pkg::PIX_W-1:0]   dc_a;
  logic [scba_pkg::PIX_W-1:0]     pa_r;
  logic                           nega_r;
  logic [2*scba_pkg::PIX_W-1:0]   dca_r;

  // Stage B: reciprocal multiply for the divide by 1275.
  logic [scba_pkg::NUM_W-1:0]     num_b;
  logic [scba_pkg::QPROD_W-1:0]   qprod_b;
  logic [scba_pkg::PIX_W-1:0]     pb_r;
  logic                           negb_r;
  logic [scba_pkg::NUM_W-1:0]     numb_r;
  logic [scba_pkg::TA_W-1:0]      qestb_r;

  // Stage C: quotient correction and saturation.
  logic [scba_pkg::NUM_W-1:0]     qmul_c;
  logic [scba_pkg::NUM_W-1:0]     rem_c;
  logic [scba_pkg::TA_W:0]        ta13_c;
  logic [scba_pkg::TA_W-1:0]      ta_c;
  logic [scba_pkg::PIX_W-1:0]     pc_r;
  logic                           negc_r;
  logic [scba_pkg::TA_W-1:0]      tac_r;

  // Stage D: table lookup and interpolation product.
  logic [scba_pkg::IDX_W:0]       idx_d;
  logic [scba_pkg::SIG_W-1:0]     a_d;
  logic [scba_pkg::SIG_W-1:0]     b_d;
  logic [scba_pkg::SIG_W-1:0]     delta_d;
  logic [scba_pkg::IPROD_W-1:0]   iprod_d;
  logic [scba_pkg::PIX_W-1:0]     pd_r;
  logic                           negd_r;
  logic [scba_pkg::SIG_W-1:0]     ad_r;
  logic [scba_pkg::IPROD_W-1:0]   iprodd_r;

  // Stage E: sigmoid value and gain.
  logic [scba_pkg::IPROD_W-1:0]   rnd_e;
  logic [scba_pkg::SIG_W-1:0]     s_e;
  logic [scba_pkg::SIG_W-1:0]     sadj_e;
  logic [scba_pkg::SIG_W-1:0]     sum_e;
  logic [scba_pkg::GSH_W-1:0]     gsh_e;
  logic [scba_pkg::PIX_W-1:0]     pe_r;
  logic [scba_pkg::GAIN_W-1:0]    gaine_r;

  // Stage F: apply gain and offset, round and saturate.
  logic [scba_pkg::Y_W-1:0]       y_f;
  logic [scba_pkg::Q_W-1:0]       q_f;
  logic [scba_pkg::Q_W-1:0]       qm_f;
  logic [scba_pkg::PIX_W-1:0]     res_f;
  logic [scba_pkg::PIX_W-1:0]     pix_r;

  always_comb begin
    dbl   = {pix_i, 1'b0};
    neg_a = dbl < 9'd255;
    dist9 = neg_a ? (9'd255 - dbl) : (dbl - 9'd255);
    dc_a  = 16'(dist9[scba_pkg::PIX_W-1:0]) * 16'(contrast_i);
  end

  always_comb begin
    num_b   = {dca_r, 6'b0} + scba_pkg::DIV_BIAS;
    qprod_b = scba_pkg::QPROD_W'(num_b) * scba_pkg::QPROD_W'(scba_pkg::DIV_RECIP);
  end

  // The reciprocal estimate is the true quotient or one below it.
  always_comb begin
    qmul_c = scba_pkg::NUM_W'(qestb_r) * scba_pkg::DIV_DEN;
    rem_c  = numb_r - qmul_c;
    ta13_c = {1'b0, qestb_r} + 13'(rem_c >= scba_pkg::DIV_DEN);
    ta_c   = (ta13_c > scba_pkg::TA_MAX) ? scba_pkg::TA_MAX[scba_pkg::TA_W-1:0]
                                         : ta13_c[scba_pkg::TA_W-1:0];
  end

  always_comb begin
    idx_d   = {1'b0, tac_r[scba_pkg::TA_W-1 -: scba_pkg::IDX_W]};
    a_d     = scba_pkg::sig_val(idx_d);
    b_d     = scba_pkg::sig_val(idx_d + 6'd1);
    delta_d = b_d - a_d;
    iprod_d = scba_pkg::IPROD_W'(delta_d) *
              scba_pkg::IPROD_W'(tac_r[scba_pkg::FRAC_W-1:0]);
  end

  always_comb begin
    rnd_e  = iprodd_r + 24'd64;
    s_e    = ad_r + scba_pkg::SIG_W'(rnd_e[scba_pkg::IPROD_W-1:scba_pkg::FRAC_W]);
    sadj_e = negd_r ? (scba_pkg::SIG_ONE - s_e) : s_e;
    sum_e  = sadj_e + scba_pkg::GAIN_BIAS;
    gsh_e  = {1'b0, sum_e, {scba_pkg::GAIN_FRAC_BITS{1'b0}}} + scba_pkg::GSH_W'(32768);
  end

  always_comb begin
    y_f = scba_pkg::Y_W'(pe_r) * scba_pkg::Y_W'(gaine_r)
        + (scba_pkg::Y_W'(brightness_i) << scba_pkg::GAIN_FRAC_BITS)
        + (scba_pkg::Y_W'(1) << (scba_pkg::GAIN_FRAC_BITS - 1));
    q_f  = y_f[scba_pkg::Y_W-1:scba_pkg::GAIN_FRAC_BITS];
    qm_f = q_f - scba_pkg::BRIGHT_OFFS;
    if (q_f < scba_pkg::BRIGHT_OFFS) begin
      res_f = '0;
    end else if (qm_f > scba_pkg::PIX_MAX) begin
      res_f = scba_pkg::PIX_MAX[scba_pkg::PIX_W-1:0];
    end else begin
      res_f = qm_f[scba_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      pa_r   <= pix_i;
      nega_r <= neg_a;
      dca_r  <= dc_a;
    end
    if (ctl.load[1]) begin
      pb_r    <= pa_r;
      negb_r  <= nega_r;
      numb_r  <= num_b;
      qestb_r <= qprod_b[scba_pkg::RECIP_SHIFT +: scba_pkg::TA_W];
    end
    if (ctl.load[2]) begin
      pc_r   <= pb_r;
      negc_r <= negb_r;
      tac_r  <= ta_c;
    end
    if (ctl.load[3]) begin
      pd_r     <= pc_r;
      negd_r   <= negc_r;
      ad_r     <= a_d;
      iprodd_r <= iprod_d;
    end
    if (ctl.load[4]) begin
      pe_r    <= pd_r;
      gaine_r <= gsh_e[16 +: scba_pkg::GAIN_W];
    end
    if (ctl.load[5]) begin
      pix_r <= res_f;
    end
  end

  assign pix_o = pix_r;

endmodule

>>> src/sigmoid_contrast_brightness_adjust_core.sv
// Sigmoid contrast and brightness adjustment of an RGB pixel stream.
//
// in_ch carries one pixel per item (blue, green, red, 8 bits each) and out_ch
// returns the adjusted pixel, one result item for every input item, in order.
// Both use valid/ready; an item moves at a clock edge with valid and ready high.
// cfg_ch writes the contrast (index 0) and brightness (index 1) registers and
// is always ready. Change them only while no pixel is in flight.
//
// Each channel runs through a six-stage pipeline: |2p-255| times contrast,
// a reciprocal multiply for the divide by 1275, quotient correction, sigmoid
// table lookup and interpolation product, gain, and the final multiply with
// rounding and saturation. An accepted item raises out valid once it
// reaches the last stage and leaves when out_ch is ready. Throughput is
// one pixel per clock while out_ch is ready; the clock period is set by
// the 22 x 22 bit reciprocal multiplier stage.
//
// When out_ch stalls, the stages fill up behind the waiting result and
// in_ch.ready drops only once every stage holds a pixel. Nothing is lost or
// repeated. A synchronous reset (rst_n low) empties the pipeline and sets
// contrast to 20 and brightness to 100.
module sigmoid_contrast_brightness_adjust_core (
  input  logic       clk,
  input  logic       rst_n,
  scba_in_if.sink    in_ch,
  scba_out_if.source out_ch,
  scba_cfg_if.sink   cfg_ch
);

  logic [scba_pkg::STAGES-1:0] vld_r;
  logic [scba_pkg::STAGES-1:0] vld_nxt;
  logic [scba_pkg::STAGES-1:0] adv;
  logic [scba_pkg::CFG_W-1:0]  contrast_r;
  logic [scba_pkg::CFG_W-1:0]  brightness_r;
  scba_pkg::scba_ctl_t         ctl;

  // A stage may load when it is empty or its item moves on this cycle.
  always_comb begin
    adv[scba_pkg::STAGES-1] = !vld_r[scba_pkg::STAGES-1] || out_ch.ready;
    for (int k = scba_pkg::STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    for (int k = 0; k < scba_pkg::STAGES; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = (k == 0) ? in_ch.valid : vld_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      contrast_r   <= scba_pkg::CONTRAST_RST;
      brightness_r <= scba_pkg::BRIGHTNESS_RST;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          scba_pkg::REG_CONTRAST:   contrast_r   <= cfg_ch.data;
          scba_pkg::REG_BRIGHTNESS: brightness_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  assign ctl.load     = adv;
  assign in_ch.ready  = adv[0];
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = vld_r[scba_pkg::STAGES-1];

  scba_chan u_blue (
    .clk          (clk),
    .ctl          (ctl),
    .pix_i        (in_ch.in_blue),
    .contrast_i   (contrast_r),
    .brightness_i (brightness_r),
    .pix_o        (out_ch.out_blue)
  );

  scba_chan u_green (
    .clk          (clk),
    .ctl          (ctl),
    .pix_i        (in_ch.in_green),
    .contrast_i   (contrast_r),
    .brightness_i (brightness_r),
    .pix_o        (out_ch.out_green)
  );

  scba_chan u_red (
    .clk          (clk),
    .ctl          (ctl),
    .pix_i        (in_ch.in_red),
    .contrast_i   (contrast_r),
    .brightness_i (brightness_r),
    .pix_o        (out_ch.out_red)
  );

`ifndef NO_ASSERTIONS
  // Input backpressure only appears once every stage is occupied.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (vld_r == '1))
    else $error("input stalled with an empty pipeline stage");

  // An accepted item occupies the first stage on the next cycle.
  a_accept_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted item missing from first stage");

  // A stalled result keeps every stage behind it occupied.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r == '1 && !out_ch.ready) |=> (vld_r == '1))
    else $error("item dropped while output stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> dv/tb_sigmoid_contrast_brightness_adjust_core.sv
module tb_sigmoid_contrast_brightness_adjust_core;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 112;
  localparam int BURST_ITEMS     = 30;
  localparam int HOLD_CYCLES     = 40;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DIR_ROWS        = 24;

  localparam longint unsigned Q16_ONE    = 65536;
  localparam longint unsigned GAIN_OFFS  = 19661;
  localparam longint unsigned T_DEN      = 1275;
  localparam longint unsigned T_HALF     = 637;
  localparam longint unsigned T_SAT      = 4095;
  localparam longint unsigned BRIGHT_ZERO = 100;
  localparam longint unsigned CHAN_MAX   = 255;

  // sigmoid(k/2) for k = 0..32 in Q1.16.
  localparam longint unsigned SIGMOID_LUT [33] = '{
    32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615,
    64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500,
    65514, 65523, 65528, 65531, 65533, 65534, 65535, 65535,
    65536, 65536, 65536, 65536, 65536, 65536, 65536, 65536,
    65536
  };

  typedef struct packed {
    logic [scba_pkg::PIX_W-1:0] blue;
    logic [scba_pkg::PIX_W-1:0] green;
    logic [scba_pkg::PIX_W-1:0] red;
  } pix_t;

  typedef enum logic {ROW_PIX, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [scba_pkg::CFG_IDX_W-1:0] idx;
    logic [scba_pkg::CFG_W-1:0]     val;
    pix_t                           pix;
    logic                           typed;
    pix_t                           want;
  } dir_row_t;

  // Rows with typed results are the ones that follow directly from the
  // brightness offset or from saturation.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd0,   8'd0,   8'd0},   1'b1,
      '{8'd0,   8'd0,   8'd0}},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd127, 8'd128, 8'd1},   1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd254, 8'd126, 8'd129}, 1'b0, '0},
    '{ROW_REG, scba_pkg::REG_BRIGHTNESS, 8'd200, '0,                        1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd0,   8'd255, 8'd0},   1'b1,
      '{8'd100, 8'd255, 8'd100}},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd127, 8'd128, 8'd64},  1'b0, '0},
    '{ROW_REG, scba_pkg::REG_CONTRAST,   8'd0,   '0,                        1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd0,   8'd128, 8'd255}, 1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd127, 8'd128, 8'd200}, 1'b0, '0},
    '{ROW_REG, scba_pkg::REG_CONTRAST,   8'd255, '0,                        1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd0,   8'd255, 8'd127}, 1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd128, 8'd1,   8'd254}, 1'b0, '0},
    '{ROW_REG, scba_pkg::REG_BRIGHTNESS, 8'd255, '0,                        1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd0,   8'd0,   8'd0},   1'b1,
      '{8'd155, 8'd155, 8'd155}},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd255, 8'd255, 8'd255}},
    '{ROW_REG, scba_pkg::REG_BRIGHTNESS, 8'd0,   '0,                        1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd0,   8'd0,   8'd0},   1'b1,
      '{8'd0,   8'd0,   8'd0}},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd255, 8'd170, 8'd85},  1'b0, '0},
    '{ROW_REG, scba_pkg::REG_CONTRAST,   8'd200, '0,                        1'b0, '0},
    '{ROW_REG, scba_pkg::REG_BRIGHTNESS, 8'd100, '0,                        1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd0,   8'd255, 8'd127}, 1'b0, '0},
    '{ROW_PIX, scba_pkg::REG_CONTRAST,   8'd0,   '{8'd128, 8'd64,  8'd192}, 1'b0, '0},
    '{ROW_REG, scba_pkg::REG_CONTRAST,   8'd20,  '0,                        1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  scba_in_if  in_ch ();
  scba_out_if out_ch ();
  scba_cfg_if cfg_ch ();

  sigmoid_contrast_brightness_adjust_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #5 clk = ~clk;

  logic [scba_pkg::CFG_W-1:0] contrast_q;
  logic [scba_pkg::CFG_W-1:0] brightness_q;
  pix_t             pending_pix [$];
  int               mismatches = 0;
  bit               hold_req = 1'b0;
  bit               calm = 1'b0;

  function automatic logic [scba_pkg::PIX_W-1:0] tone_channel(
      logic [scba_pkg::PIX_W-1:0] p,
      logic [scba_pkg::CFG_W-1:0] con,
      logic [scba_pkg::CFG_W-1:0] bri);
    longint unsigned pv, span, tq, seg, frac, lo, hi, sig, gsum, gain, acc;
    bit below;
    pv    = p;
    below = (2 * pv) < CHAN_MAX;
    span  = below ? (CHAN_MAX - 2 * pv) : (2 * pv - CHAN_MAX);
    tq    = (span * con * 64 + T_HALF) / T_DEN;
    if (tq > T_SAT)
      tq = T_SAT;
    seg  = tq >> 7;
    frac = tq & 127;
    lo   = SIGMOID_LUT[seg];
    hi   = SIGMOID_LUT[seg + 1];
    sig  = lo + (((hi - lo) * frac + 64) >> 7);
    // The sigmoid is odd around one half, so the lower side mirrors the upper.
    if (below)
      sig = Q16_ONE - sig;
    gsum = sig + GAIN_OFFS;
    gain = ((gsum << scba_pkg::GAIN_FRAC_BITS) + (Q16_ONE >> 1)) >> 16;
    acc  = (pv * gain + (longint'(bri) << scba_pkg::GAIN_FRAC_BITS)
            + (64'd1 << (scba_pkg::GAIN_FRAC_BITS - 1))) >> scba_pkg::GAIN_FRAC_BITS;
    if (acc < BRIGHT_ZERO)
      return '0;
    acc = acc - BRIGHT_ZERO;
    if (acc > CHAN_MAX)
      acc = CHAN_MAX;
    return acc[scba_pkg::PIX_W-1:0];
  endfunction

  function automatic pix_t tone_pixel(pix_t px);
    pix_t r;
    r.blue  = tone_channel(px.blue,  contrast_q, brightness_q);
    r.green = tone_channel(px.green, contrast_q, brightness_q);
    r.red   = tone_channel(px.red,   contrast_q, brightness_q);
    return r;
  endfunction

  function automatic logic [scba_pkg::PIX_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127;
      3:       return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t rand_pixel();
    pix_t r;
    r.blue  = rand_chan();
    r.green = rand_chan();
    r.red   = rand_chan();
    return r;
  endfunction

  function automatic logic [scba_pkg::CFG_W-1:0] rand_setting();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd200;
      2:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(pix_t px, logic typed, pix_t want);
    in_ch.valid    <= 1'b1;
    in_ch.in_blue  <= px.blue;
    in_ch.in_green <= px.green;
    in_ch.in_red   <= px.red;
    cfg_ch.valid   <= 1'b0;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (typed)
      pending_pix.push_back(want);
    else
      pending_pix.push_back(tone_pixel(px));
  endtask

  // The config write leaves valid high; the next pixel lowers it, so that
  // back-to-back writes never drop and raise valid in one step.
  task automatic write_reg(logic [scba_pkg::CFG_IDX_W-1:0] idx,
                           logic [scba_pkg::CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    case (idx)
      scba_pkg::REG_CONTRAST:   contrast_q = val;
      scba_pkg::REG_BRIGHTNESS: brightness_q = val;
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (pending_pix.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    pix_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pix.size() == 0) begin
        $error("out_ch: result item with no pixel outstanding");
        mismatches++;
      end else begin
        want = pending_pix.pop_front();
        if (out_ch.out_blue !== want.blue) begin
          $error("out_blue: expected %0d, actual %0d", want.blue, out_ch.out_blue);
          mismatches++;
        end
        if (out_ch.out_green !== want.green) begin
          $error("out_green: expected %0d, actual %0d", want.green, out_ch.out_green);
          mismatches++;
        end
        if (out_ch.out_red !== want.red) begin
          $error("out_red: expected %0d, actual %0d", want.red, out_ch.out_red);
          mismatches++;
        end
      end
    end
  end

  initial begin : sink_ready
    int stretch;
    stretch = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (calm || stretch > 0) begin
        out_ch.ready <= 1'b1;
        if (stretch > 0)
          stretch--;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 19) == 0)
          stretch = $urandom_range(20, 60);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("sigmoid_contrast_brightness_adjust_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_blue  <= '0;
    in_ch.in_green <= '0;
    in_ch.in_red   <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= scba_pkg::REG_CONTRAST;
    cfg_ch.data    <= '0;
    contrast_q     = scba_pkg::CONTRAST_RST;
    brightness_q   = scba_pkg::BRIGHTNESS_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_REG) begin
        wait_drain();
        write_reg(dir_tab[r].idx, dir_tab[r].val);
      end else begin
        send_pixel(dir_tab[r].pix, dir_tab[r].typed, dir_tab[r].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drain();
      write_reg(scba_pkg::REG_CONTRAST, rand_setting());
      write_reg(scba_pkg::REG_BRIGHTNESS, rand_setting());
      calm = (ph == PHASES - 1);
      // Stall the output for a long stretch while pixels keep coming, so the
      // pipeline fills and backpressure reaches the input.
      if (ph == 2) begin
        hold_req = 1'b1;
        repeat (BURST_ITEMS) send_pixel(rand_pixel(), 1'b0, '0);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          in_ch.valid  <= 1'b0;
          cfg_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        send_pixel(rand_pixel(), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (2 * scba_pkg::STAGES) @(posedge clk);
    if (mismatches == 0)
      $display("sigmoid_contrast_brightness_adjust_core: match");
    else
      $display("sigmoid_contrast_brightness_adjust_core: mismatch");
    $finish;
  end

endmodule
